[src/gspl_pkg.sv]
package gspl_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int FULL_SCALE  = 1 << SAMPLE_BITS;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	localparam logic [2:0] REG_LOAD_RES    = 3'd0;
	localparam logic [2:0] REG_CLEAN_AIR   = 3'd1;
	localparam logic [2:0] REG_LPG_X0      = 3'd2;
	localparam logic [2:0] REG_LPG_Y0      = 3'd3;
	localparam logic [2:0] REG_LPG_SLOPE   = 3'd4;
	localparam logic [2:0] REG_SMOKE_X0    = 3'd5;
	localparam logic [2:0] REG_SMOKE_Y0    = 3'd6;
	localparam logic [2:0] REG_SMOKE_SLOPE = 3'd7;

	localparam logic [7:0]  RST_LOAD_RES    = 8'd10;
	localparam logic [23:0] RST_CLEAN_AIR   = 24'd2560;
	localparam logic [15:0] RST_LPG_X0      = 16'd9421;
	localparam logic [15:0] RST_LPG_Y0      = 16'd819;
	localparam logic [15:0] RST_LPG_SLOPE   = 16'hF8CD;
	localparam logic [15:0] RST_SMOKE_X0    = 16'd9421;
	localparam logic [15:0] RST_SMOKE_Y0    = 16'd2171;
	localparam logic [15:0] RST_SMOKE_SLOPE = 16'hF91F;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic [1:0] CLS_CURVE  = 2'd0;
	localparam logic [1:0] CLS_PASS   = 2'd1;
	localparam logic [1:0] CLS_DIVERR = 2'd2;
	localparam logic [1:0] CLS_SLOPE0 = 2'd3;

	typedef struct packed {
		logic [1:0]             command;
		logic [SAMPLE_BITS-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [31:0] ppm_value;
		logic [1:0]  status;
	} out_item_t;

	typedef logic [15:0][30:0] exp_k_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] v;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		v = x;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-(k+1)) in Q1.30
	function automatic exp_k_t exp_k_table();
		exp_k_t      t;
		logic [63:0] k;
		k = isqrt64(64'd1 << 61);
		t[0] = k[30:0];
		for (int i = 1; i < 16; i++) begin
			k = isqrt64(k << 30);
			t[i] = k[30:0];
		end
		return t;
	endfunction

	localparam exp_k_t EXP_K = exp_k_table();

endpackage

[src/gas_sensor_ppm_linearizer_top.sv]
// throughput: one item per cycle unless out_stall holds it; fully pipelined, single stall enable
// depth is set by the 45-step and 29-step long-division pipelines and the
// 16-step log squaring and exponent multiply chains, one step per stage
// reset clears all valid bits and loads the default configuration registers
module gas_sensor_ppm_linearizer_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  gspl_pkg::in_item_t       in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output gspl_pkg::out_item_t      out_data,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [gspl_pkg::ADDR_W-1:0] paddr,
	input  logic [gspl_pkg::DATA_W-1:0] pwdata,
	output logic [gspl_pkg::DATA_W-1:0] prdata,
	output logic                     pready
);

	localparam int SB    = gspl_pkg::SAMPLE_BITS;
	localparam int NP_W  = 8 + SB + 1;
	localparam int N1_W  = NP_W + 24;
	localparam int D1_W  = SB + 24;
	localparam int N2_W  = 29;
	localparam int D2_W  = 16;

	typedef struct packed {
		logic [1:0]    cls;
		logic          curve;
		logic [SB-1:0] sample;
	} tag_t;

	typedef struct packed {
		tag_t tag;
		logic sat;
		logic neg;
	} tag2_t;

	localparam int TAG_W  = $bits(tag_t);
	localparam int TAG2_W = $bits(tag2_t);

	// configuration registers
	logic [7:0]         rl_q;
	logic [23:0]        ro_q;
	logic signed [15:0] lpg_x0_q;
	logic signed [15:0] lpg_y0_q;
	logic signed [15:0] lpg_slope_q;
	logic signed [15:0] smoke_x0_q;
	logic signed [15:0] smoke_y0_q;
	logic signed [15:0] smoke_slope_q;
	logic               wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rl_q          <= gspl_pkg::RST_LOAD_RES;
			ro_q          <= gspl_pkg::RST_CLEAN_AIR;
			lpg_x0_q      <= gspl_pkg::RST_LPG_X0;
			lpg_y0_q      <= gspl_pkg::RST_LPG_Y0;
			lpg_slope_q   <= gspl_pkg::RST_LPG_SLOPE;
			smoke_x0_q    <= gspl_pkg::RST_SMOKE_X0;
			smoke_y0_q    <= gspl_pkg::RST_SMOKE_Y0;
			smoke_slope_q <= gspl_pkg::RST_SMOKE_SLOPE;
		end else if (wr) begin
			unique case (paddr[4:2])
				gspl_pkg::REG_LOAD_RES:    rl_q          <= pwdata[7:0];
				gspl_pkg::REG_CLEAN_AIR:   ro_q          <= pwdata[23:0];
				gspl_pkg::REG_LPG_X0:      lpg_x0_q      <= pwdata[15:0];
				gspl_pkg::REG_LPG_Y0:      lpg_y0_q      <= pwdata[15:0];
				gspl_pkg::REG_LPG_SLOPE:   lpg_slope_q   <= pwdata[15:0];
				gspl_pkg::REG_SMOKE_X0:    smoke_x0_q    <= pwdata[15:0];
				gspl_pkg::REG_SMOKE_Y0:    smoke_y0_q    <= pwdata[15:0];
				gspl_pkg::REG_SMOKE_SLOPE: smoke_slope_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			gspl_pkg::REG_LOAD_RES:    prdata = 32'(rl_q);
			gspl_pkg::REG_CLEAN_AIR:   prdata = 32'(ro_q);
			gspl_pkg::REG_LPG_X0:      prdata = {16'd0, lpg_x0_q};
			gspl_pkg::REG_LPG_Y0:      prdata = {16'd0, lpg_y0_q};
			gspl_pkg::REG_LPG_SLOPE:   prdata = {16'd0, lpg_slope_q};
			gspl_pkg::REG_SMOKE_X0:    prdata = {16'd0, smoke_x0_q};
			gspl_pkg::REG_SMOKE_Y0:    prdata = {16'd0, smoke_y0_q};
			gspl_pkg::REG_SMOKE_SLOPE: prdata = {16'd0, smoke_slope_q};
			default:                   prdata = '0;
		endcase
	end

	// pipeline enable
	logic                out_valid_q;
	gspl_pkg::out_item_t out_q;
	logic                en;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// stage 1: classify, resistance products
	logic signed [15:0] slope_in;
	logic [SB:0]        diff_in;
	logic [NP_W-1:0]    nump_in;
	logic [D1_W-1:0]    denp_in;
	tag_t               tag_in;

	assign slope_in = in_data.command[0] ? smoke_slope_q : lpg_slope_q;
	assign diff_in  = (SB+1)'(gspl_pkg::FULL_SCALE) - {1'b0, in_data.sample};
	assign nump_in  = NP_W'(rl_q) * NP_W'(diff_in);
	assign denp_in  = D1_W'(in_data.sample) * D1_W'(ro_q);

	always_comb begin
		tag_in.curve  = in_data.command[0];
		tag_in.sample = in_data.sample;
		priority if (in_data.command[1]) begin
			tag_in.cls = gspl_pkg::CLS_PASS;
		end else if (in_data.sample == '0 || ro_q == '0) begin
			tag_in.cls = gspl_pkg::CLS_DIVERR;
		end else if (slope_in == '0) begin
			tag_in.cls = gspl_pkg::CLS_SLOPE0;
		end else begin
			tag_in.cls = gspl_pkg::CLS_CURVE;
		end
	end

	logic            v_s1;
	tag_t            tag_s1;
	logic [NP_W-1:0] nump_s1;
	logic [D1_W-1:0] denp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1  <= tag_in;
			nump_s1 <= nump_in;
			denp_s1 <= denp_in;
		end
	end

	// ratio Q.16 by long division
	logic             v_d1;
	logic [N1_W-1:0]  ratio_d1;
	logic [TAG_W-1:0] tagv_d1;
	tag_t             tag_d1;

	gspl_div #(.NW(N1_W), .DW(D1_W), .SW(TAG_W)) u_div_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.num      ({nump_s1, 24'd0}),
		.den      (denp_s1),
		.side_in  (tag_s1),
		.out_valid(v_d1),
		.quo      (ratio_d1),
		.side_out (tagv_d1)
	);

	assign tag_d1 = tagv_d1;

	// stage 2: leading one
	logic [5:0]      p_lz;
	logic            v_s2;
	logic [N1_W-1:0] ratio_s2;
	logic [5:0]      p_s2;
	logic            zero_s2;
	tag_t            tag_s2;

	always_comb begin
		p_lz = '0;
		for (int i = 0; i < N1_W; i++) begin
			if (ratio_d1[i]) begin
				p_lz = 6'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_s2 <= ratio_d1;
			p_s2     <= p_lz;
			zero_s2  <= ratio_d1 == '0;
			tag_s2   <= tag_d1;
		end
	end

	// stage 3: normalize to Q1.30
	logic [30:0] m_norm;
	logic        v_s3;
	logic [30:0] m_s3;
	logic [5:0]  p_s3;
	logic        zero_s3;
	tag_t        tag_s3;

	always_comb begin
		if (p_s2 > 6'd30) begin
			m_norm = 31'(ratio_s2 >> (p_s2 - 6'd30));
		end else begin
			m_norm = 31'(ratio_s2 << (6'd30 - p_s2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3    <= m_norm;
			p_s3    <= p_s2;
			zero_s3 <= zero_s2;
			tag_s3  <= tag_s2;
		end
	end

	// log2 fraction, one squaring per stage
	logic        vld_sq  [16];
	logic [30:0] m_sq    [16];
	logic [15:0] f_sq    [16];
	logic [5:0]  p_sq    [16];
	logic        zero_sq [16];
	tag_t        tag_sq  [16];

	for (genvar k = 0; k < 16; k++) begin : g_sq
		logic        vld_i;
		logic [30:0] m_i;
		logic [15:0] f_i;
		logic [5:0]  p_i;
		logic        zero_i;
		tag_t        tag_i;
		logic [61:0] sq;
		logic [31:0] sq_hi;

		if (k == 0) begin : g_first
			assign vld_i  = v_s3;
			assign m_i    = m_s3;
			assign f_i    = '0;
			assign p_i    = p_s3;
			assign zero_i = zero_s3;
			assign tag_i  = tag_s3;
		end else begin : g_next
			assign vld_i  = vld_sq[k-1];
			assign m_i    = m_sq[k-1];
			assign f_i    = f_sq[k-1];
			assign p_i    = p_sq[k-1];
			assign zero_i = zero_sq[k-1];
			assign tag_i  = tag_sq[k-1];
		end

		assign sq    = 62'(m_i) * 62'(m_i);
		assign sq_hi = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq[k] <= 1'b0;
			end else if (en) begin
				vld_sq[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_sq[k]    <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
				f_sq[k]    <= {f_i[14:0], sq_hi[31]};
				p_sq[k]    <= p_i;
				zero_sq[k] <= zero_i;
				tag_sq[k]  <= tag_i;
			end
		end
	end

	// stage 4: log2 times log10(2)
	logic signed [22:0] lg2_n;
	logic signed [42:0] lgp_n;
	logic               v_s4;
	logic signed [42:0] lgp_s4;
	logic               zero_s4;
	tag_t               tag_s4;

	assign lg2_n = $signed({1'b0, p_sq[15], f_sq[15]}) - 23'sd1048576;
	assign lgp_n = 43'(lg2_n) * 43'sd315653;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= vld_sq[15];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lgp_s4  <= lgp_n;
			zero_s4 <= zero_sq[15];
			tag_s4  <= tag_sq[15];
		end
	end

	// stage 5: round to Q4.12 and clamp
	logic [42:0]        lmag;
	logic [42:0]        lsum;
	logic signed [19:0] lgr;
	logic signed [15:0] lg_n;
	logic               lsat_n;
	logic               v_s5;
	logic signed [15:0] lg_s5;
	logic               sat_s5;
	tag_t               tag_s5;

	assign lmag = lgp_s4[42] ? 43'(-lgp_s4) : 43'(lgp_s4);
	assign lsum = lmag + 43'd8388608;
	assign lgr  = lgp_s4[42] ? -$signed({1'b0, lsum[42:24]}) : $signed({1'b0, lsum[42:24]});

	always_comb begin
		priority if (zero_s4) begin
			lg_n   = 16'sh8000;
			lsat_n = 1'b1;
		end else if (lgr > 20'sd32767) begin
			lg_n   = 16'sh7FFF;
			lsat_n = 1'b1;
		end else if (lgr < -20'sd32768) begin
			lg_n   = 16'sh8000;
			lsat_n = 1'b1;
		end else begin
			lg_n   = lgr[15:0];
			lsat_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lg_s5  <= lg_n;
			sat_s5 <= lsat_n;
			tag_s5 <= tag_s4;
		end
	end

	// (log - y0) * 4096 / slope, sign and magnitude
	logic signed [15:0] y0_sel;
	logic signed [15:0] slope_sel;
	logic signed [16:0] dl;
	logic [16:0]        dmag;
	logic [D2_W-1:0]    smag;
	tag2_t              side2_in;

	assign y0_sel    = tag_s5.curve ? smoke_y0_q : lpg_y0_q;
	assign slope_sel = tag_s5.curve ? smoke_slope_q : lpg_slope_q;
	assign dl        = 17'(lg_s5) - 17'(y0_sel);
	assign dmag      = dl[16] ? 17'(-dl) : 17'(dl);
	assign smag      = slope_sel[15] ? 16'(-slope_sel) : 16'(slope_sel);

	always_comb begin
		side2_in.tag = tag_s5;
		side2_in.sat = sat_s5;
		side2_in.neg = dl[16] ^ slope_sel[15];
	end

	logic              v_d2;
	logic [N2_W-1:0]   qmag_d2;
	logic [TAG2_W-1:0] side2v_d2;
	tag2_t             side2_d2;

	gspl_div #(.NW(N2_W), .DW(D2_W), .SW(TAG2_W)) u_div_curve (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.num      ({dmag, 12'd0}),
		.den      (smag),
		.side_in  (side2_in),
		.out_valid(v_d2),
		.quo      (qmag_d2),
		.side_out (side2v_d2)
	);

	assign side2_d2 = side2v_d2;

	// stage 6: add x0
	logic signed [15:0] x0_sel;
	logic signed [29:0] qs;
	logic signed [30:0] e_n;
	logic               v_s6;
	logic signed [30:0] e_s6;
	logic               sat_s6;
	tag_t               tag_s6;

	assign x0_sel = side2_d2.tag.curve ? smoke_x0_q : lpg_x0_q;
	assign qs     = side2_d2.neg ? -$signed({1'b0, qmag_d2}) : $signed({1'b0, qmag_d2});
	assign e_n    = 31'(qs) + 31'(x0_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s6   <= e_n;
			sat_s6 <= side2_d2.sat;
			tag_s6 <= side2_d2.tag;
		end
	end

	// stage 7: scale by log2(10)
	logic               v_s7;
	logic signed [49:0] wp_s7;
	logic               sat_s7;
	tag_t               tag_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wp_s7  <= 50'(e_s6) * 50'sd217706;
			sat_s7 <= sat_s6;
			tag_s7 <= tag_s6;
		end
	end

	// stage 8: round to Q.16, split integer and fraction
	logic [49:0]        wmag;
	logic [49:0]        wsum;
	logic signed [38:0] w_n;
	logic               v_s8;
	logic signed [22:0] n_s8;
	logic [15:0]        f_s8;
	logic               sat_s8;
	tag_t               tag_s8;

	assign wmag = wp_s7[49] ? 50'(-wp_s7) : 50'(wp_s7);
	assign wsum = wmag + 50'd2048;
	assign w_n  = wp_s7[49] ? -$signed({1'b0, wsum[49:12]}) : $signed({1'b0, wsum[49:12]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s8   <= w_n[38:16];
			f_s8   <= w_n[15:0];
			sat_s8 <= sat_s7;
			tag_s8 <= tag_s7;
		end
	end

	// 2^f, one constant multiply per stage
	logic               vld_ex [16];
	logic [30:0]        m_ex   [16];
	logic [15:0]        f_ex   [16];
	logic signed [22:0] n_ex   [16];
	logic               sat_ex [16];
	tag_t               tag_ex [16];

	for (genvar k = 0; k < 16; k++) begin : g_ex
		logic               vld_i;
		logic [30:0]        m_i;
		logic [15:0]        f_i;
		logic signed [22:0] n_i;
		logic               sat_i;
		tag_t               tag_i;
		logic [61:0]        prod;

		if (k == 0) begin : g_first
			assign vld_i = v_s8;
			assign m_i   = 31'h4000_0000;
			assign f_i   = f_s8;
			assign n_i   = n_s8;
			assign sat_i = sat_s8;
			assign tag_i = tag_s8;
		end else begin : g_next
			assign vld_i = vld_ex[k-1];
			assign m_i   = m_ex[k-1];
			assign f_i   = f_ex[k-1];
			assign n_i   = n_ex[k-1];
			assign sat_i = sat_ex[k-1];
			assign tag_i = tag_ex[k-1];
		end

		assign prod = 62'(m_i) * 62'(gspl_pkg::EXP_K[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_ex[k] <= 1'b0;
			end else if (en) begin
				vld_ex[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_ex[k]   <= f_i[15-k] ? prod[60:30] : m_i;
				f_ex[k]   <= f_i;
				n_ex[k]   <= n_i;
				sat_ex[k] <= sat_i;
				tag_ex[k] <= tag_i;
			end
		end
	end

	// output stage: scale to Q24.8 and select result
	logic signed [23:0]  sh;
	logic [23:0]         rsh;
	logic [5:0]          rs6;
	logic [41:0]         rt;
	logic [31:0]         val;
	logic                ovf;
	tag_t                tag_o;
	gspl_pkg::out_item_t res_n;

	assign tag_o = tag_ex[15];
	assign sh    = 24'(n_ex[15]) - 24'sd22;
	assign rsh   = 24'(-sh);
	assign rs6   = rsh[5:0];
	assign rt    = 42'(m_ex[15]) + (42'd1 << (rs6 - 6'd1));

	always_comb begin
		ovf = 1'b0;
		priority if (sh >= 24'sd2) begin
			ovf = 1'b1;
			val = '1;
		end else if (sh >= 24'sd0) begin
			val = sh[0] ? {m_ex[15], 1'b0} : {1'b0, m_ex[15]};
		end else if (rsh > 24'd40) begin
			val = '0;
		end else begin
			val = 32'(rt >> rs6);
		end
	end

	always_comb begin
		unique case (tag_o.cls)
			gspl_pkg::CLS_PASS: begin
				res_n.ppm_value = 32'({tag_o.sample, 8'd0});
				res_n.status    = gspl_pkg::ST_OK;
			end
			gspl_pkg::CLS_DIVERR: begin
				res_n.ppm_value = '0;
				res_n.status    = gspl_pkg::ST_DIV;
			end
			gspl_pkg::CLS_SLOPE0: begin
				res_n.ppm_value = '1;
				res_n.status    = gspl_pkg::ST_SAT;
			end
			default: begin
				res_n.ppm_value = val;
				res_n.status    = (sat_ex[15] || ovf) ? gspl_pkg::ST_SAT : gspl_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_ex[15];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == gspl_pkg::ST_DIV |-> out_q.ppm_value == '0)
		else $error("divide error with nonzero value");

	a_log_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sq[15] && !zero_sq[15] |-> m_sq[15][30])
		else $error("log mantissa lost normalization");

	a_exp_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_ex[15] |-> m_ex[15][30])
		else $error("exponent mantissa lost normalization");

endmodule

[src/gspl_div.sv]
module gspl_div #(
	parameter int NW = 45,
	parameter int DW = 36,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic          vld_s  [NW];
	logic [NW-1:0] num_s  [NW];
	logic [NW-1:0] quo_s  [NW];
	logic [DW-1:0] den_s  [NW];
	logic [DW-1:0] rem_s  [NW];
	logic [SW-1:0] side_s [NW];

	for (genvar i = 0; i < NW; i++) begin : g_step
		logic          vld_i;
		logic [NW-1:0] num_i;
		logic [NW-1:0] quo_i;
		logic [DW-1:0] den_i;
		logic [DW-1:0] rem_i;
		logic [SW-1:0] side_i;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign vld_i  = in_valid;
			assign num_i  = num;
			assign quo_i  = '0;
			assign den_i  = den;
			assign rem_i  = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign vld_i  = vld_s[i-1];
			assign num_i  = num_s[i-1];
			assign quo_i  = quo_s[i-1];
			assign den_i  = den_s[i-1];
			assign rem_i  = rem_s[i-1];
			assign side_i = side_s[i-1];
		end

		assign trial = {rem_i, num_i[NW-1]};
		assign diff  = trial - {1'b0, den_i};
		assign ge    = trial >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i]  <= num_i << 1;
				quo_s[i]  <= {quo_i[NW-2:0], ge};
				den_s[i]  <= den_i;
				rem_s[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				side_s[i] <= side_i;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quo       = quo_s[NW-1];
	assign side_out  = side_s[NW-1];

	a_first_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && den_s[0] != '0 |-> rem_s[0] < den_s[0])
		else $error("first step remainder not below divisor");

	a_last_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NW-1] && den_s[NW-1] != '0 |-> rem_s[NW-1] < den_s[NW-1])
		else $error("final remainder not below divisor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(quo_s[NW-1]) && $stable(side_s[NW-1]) && $stable(vld_s[NW-1]))
		else $error("divider moved while held");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam logic [1:0] CMD_LPG    = 2'd0;
	localparam logic [1:0] CMD_SMOKE  = 2'd1;
	localparam logic [1:0] CMD_RAW    = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 150;
	localparam longint CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	gspl_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	gspl_pkg::out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [gspl_pkg::ADDR_W-1:0] paddr = '0;
	logic [gspl_pkg::DATA_W-1:0] pwdata = '0;
	logic [gspl_pkg::DATA_W-1:0] prdata;
	logic pready;

	gas_sensor_ppm_linearizer_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// calibration copy
	logic [7:0] load_res;
	logic [23:0] ro_q8;
	logic signed [15:0] curve_x0 [2];
	logic signed [15:0] curve_y0 [2];
	logic signed [15:0] curve_slope [2];
	longint unsigned root_k [16];

	gspl_pkg::out_item_t ppm_queue [$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	longint cycles = 0;

	initial forever #5 clk = ~clk;

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	function automatic longint round_half_away(longint v, int sh);
		longint unsigned mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic gspl_pkg::out_item_t predict_ppm(gspl_pkg::in_item_t it);
		gspl_pkg::out_item_t r;
		int c;
		longint unsigned diff, ratio, m, frac, f;
		longint lg, e, w, n, sh, x0, y0, sl;
		int p;
		bit sat;
		sat = 0;
		if (it.command == CMD_RAW || it.command == CMD_UNUSED) begin
			r.ppm_value = {12'd0, it.sample, 8'd0};
			r.status = gspl_pkg::ST_OK;
			return r;
		end
		if (it.sample == 0 || ro_q8 == 0) begin
			r.ppm_value = '0;
			r.status = gspl_pkg::ST_DIV;
			return r;
		end
		c = (it.command == CMD_LPG) ? 0 : 1;
		x0 = curve_x0[c];
		y0 = curve_y0[c];
		sl = curve_slope[c];
		if (sl == 0) begin
			r.ppm_value = '1;
			r.status = gspl_pkg::ST_SAT;
			return r;
		end
		diff = gspl_pkg::FULL_SCALE - it.sample;
		ratio = ((longint'(load_res) * diff) << 24) / (longint'(it.sample) * ro_q8);
		if (ratio == 0) begin
			lg = -32768;
			sat = 1;
		end else begin
			p = 63;
			while (ratio[p] == 1'b0)
				p--;
			m = (p > 30) ? ratio >> (p - 30) : ratio << (30 - p);
			frac = 0;
			for (int i = 0; i < 16; i++) begin
				m = (m * m) >> 30;
				frac = frac << 1;
				if (m >= (64'd1 << 31)) begin
					frac = frac | 1;
					m = m >> 1;
				end
			end
			lg = round_half_away((longint'(p - 16) * 65536 + longint'(frac)) * 315653, 24);
			if (lg > 32767) begin
				lg = 32767;
				sat = 1;
			end
			if (lg < -32768) begin
				lg = -32768;
				sat = 1;
			end
		end
		e = (lg - y0) * 4096 / sl + x0;
		w = round_half_away(e * 217706, 12);
		n = (w >= 0) ? w / 65536 : -((-w + 65535) / 65536);
		f = w - n * 65536;
		m = 64'd1 << 30;
		for (int i = 0; i < 16; i++)
			if (f[15 - i])
				m = (m * root_k[i]) >> 30;
		sh = n - 22;
		if (sh >= 0) begin
			if (sh > 8 || (m << sh) > 64'hFFFF_FFFF) begin
				sat = 1;
				r.ppm_value = '1;
			end else begin
				r.ppm_value = 32'(m << sh);
			end
		end else if (sh < -40) begin
			r.ppm_value = '0;
		end else begin
			r.ppm_value = 32'((m + (64'd1 << (-sh - 1))) >> (-sh));
		end
		r.status = sat ? gspl_pkg::ST_SAT : gspl_pkg::ST_OK;
		return r;
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		gspl_pkg::out_item_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (ppm_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result ppm %h status %0d",
						out_data.ppm_value, out_data.status);
			end else begin
				want = ppm_queue.pop_front();
				if (want.ppm_value !== out_data.ppm_value || want.status !== out_data.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected ppm %h status %0d, got ppm %h status %0d",
							want.ppm_value, want.status, out_data.ppm_value, out_data.status);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_sample(logic [1:0] command, logic [gspl_pkg::SAMPLE_BITS-1:0] sample);
		gspl_pkg::in_item_t it;
		it.command = command;
		it.sample = sample;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		ppm_queue.push_back(predict_ppm(it));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (ppm_queue.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= gspl_pkg::ADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			gspl_pkg::REG_LOAD_RES:    load_res = value[7:0];
			gspl_pkg::REG_CLEAN_AIR:   ro_q8 = value[23:0];
			gspl_pkg::REG_LPG_X0:      curve_x0[0] = value[15:0];
			gspl_pkg::REG_LPG_Y0:      curve_y0[0] = value[15:0];
			gspl_pkg::REG_LPG_SLOPE:   curve_slope[0] = value[15:0];
			gspl_pkg::REG_SMOKE_X0:    curve_x0[1] = value[15:0];
			gspl_pkg::REG_SMOKE_Y0:    curve_y0[1] = value[15:0];
			gspl_pkg::REG_SMOKE_SLOPE: curve_slope[1] = value[15:0];
		endcase
	endtask

	function automatic logic [15:0] pick_q12(logic [15:0] nominal);
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom);
			3: return 16'h0000;
			default: return nominal + 16'($signed($urandom_range(0, 1200)) - 600);
		endcase
	endfunction

	function automatic logic [15:0] pick_slope(logic [15:0] nominal);
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom);
			3: return 16'h0001;
			default: return nominal + 16'($signed($urandom_range(0, 1000)) - 500);
		endcase
	endfunction

	task automatic randomize_calibration();
		wait_idle();
		write_reg(gspl_pkg::REG_LOAD_RES,
			($urandom_range(3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 40));
		case ($urandom_range(4))
			0: write_reg(gspl_pkg::REG_CLEAN_AIR, 32'h00FF_FFFF);
			1: write_reg(gspl_pkg::REG_CLEAN_AIR, 32'd1);
			default: write_reg(gspl_pkg::REG_CLEAN_AIR, $urandom_range(256, 16000));
		endcase
		write_reg(gspl_pkg::REG_LPG_X0, 32'(pick_q12(gspl_pkg::RST_LPG_X0)));
		write_reg(gspl_pkg::REG_LPG_Y0, 32'(pick_q12(gspl_pkg::RST_LPG_Y0)));
		write_reg(gspl_pkg::REG_LPG_SLOPE, 32'(pick_slope(gspl_pkg::RST_LPG_SLOPE)));
		write_reg(gspl_pkg::REG_SMOKE_X0, 32'(pick_q12(gspl_pkg::RST_SMOKE_X0)));
		write_reg(gspl_pkg::REG_SMOKE_Y0, 32'(pick_q12(gspl_pkg::RST_SMOKE_Y0)));
		write_reg(gspl_pkg::REG_SMOKE_SLOPE, 32'(pick_slope(gspl_pkg::RST_SMOKE_SLOPE)));
	endtask

	task automatic restore_defaults();
		wait_idle();
		write_reg(gspl_pkg::REG_LOAD_RES, 32'(gspl_pkg::RST_LOAD_RES));
		write_reg(gspl_pkg::REG_CLEAN_AIR, 32'(gspl_pkg::RST_CLEAN_AIR));
		write_reg(gspl_pkg::REG_LPG_X0, 32'(gspl_pkg::RST_LPG_X0));
		write_reg(gspl_pkg::REG_LPG_Y0, 32'(gspl_pkg::RST_LPG_Y0));
		write_reg(gspl_pkg::REG_LPG_SLOPE, 32'(gspl_pkg::RST_LPG_SLOPE));
		write_reg(gspl_pkg::REG_SMOKE_X0, 32'(gspl_pkg::RST_SMOKE_X0));
		write_reg(gspl_pkg::REG_SMOKE_Y0, 32'(gspl_pkg::RST_SMOKE_Y0));
		write_reg(gspl_pkg::REG_SMOKE_SLOPE, 32'(gspl_pkg::RST_SMOKE_SLOPE));
	endtask

	task automatic test_reset_curves();
		send_sample(CMD_LPG, 12'd0);
		send_sample(CMD_LPG, 12'd1);
		send_sample(CMD_LPG, 12'd4095);
		send_sample(CMD_SMOKE, 12'd2048);
		send_sample(CMD_SMOKE, 12'd1);
		send_sample(CMD_RAW, 12'd0);
		send_sample(CMD_RAW, 12'hFFF);
		send_sample(CMD_UNUSED, 12'hA5A);
		send_sample(CMD_LPG, 12'd3000);
	endtask

	task automatic test_special_settings();
		restore_defaults();
		write_reg(gspl_pkg::REG_LPG_SLOPE, 32'd0);
		write_reg(gspl_pkg::REG_CLEAN_AIR, 32'h00FF_FFFF);
		write_reg(gspl_pkg::REG_LOAD_RES, 32'd255);
		send_sample(CMD_LPG, 12'd100);
		send_sample(CMD_SMOKE, 12'd1);
		send_sample(CMD_SMOKE, 12'd4095);
		wait_idle();
		write_reg(gspl_pkg::REG_CLEAN_AIR, 32'd0);
		send_sample(CMD_SMOKE, 12'd500);
		send_sample(CMD_RAW, 12'd500);
		wait_idle();
		write_reg(gspl_pkg::REG_CLEAN_AIR, 32'd1);
		write_reg(gspl_pkg::REG_SMOKE_X0, 32'h0000_7FFF);
		write_reg(gspl_pkg::REG_SMOKE_SLOPE, 32'h0000_8000);
		send_sample(CMD_SMOKE, 12'd1);
		send_sample(CMD_SMOKE, 12'd4095);
		wait_idle();
		write_reg(gspl_pkg::REG_LPG_SLOPE, 32'h0000_0001);
		send_sample(CMD_LPG, 12'd2000);
		send_sample(CMD_LPG, 12'd1);
	endtask

	task automatic test_random_samples(int send_pct, int recv_pct, int count);
		logic [1:0] command;
		logic [gspl_pkg::SAMPLE_BITS-1:0] sample;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				randomize_calibration();
			command = ($urandom_range(9) < 8) ? 2'($urandom_range(1)) : 2'($urandom_range(2, 3));
			case ($urandom_range(9))
				0: sample = gspl_pkg::SAMPLE_BITS'($urandom_range(0, 3));
				1: sample = gspl_pkg::SAMPLE_BITS'($urandom_range(4090, 4095));
				default: sample = gspl_pkg::SAMPLE_BITS'($urandom);
			endcase
			send_sample(command, sample);
		end
	endtask

	initial begin
		load_res = gspl_pkg::RST_LOAD_RES;
		ro_q8 = gspl_pkg::RST_CLEAN_AIR;
		curve_x0[0] = gspl_pkg::RST_LPG_X0;
		curve_y0[0] = gspl_pkg::RST_LPG_Y0;
		curve_slope[0] = gspl_pkg::RST_LPG_SLOPE;
		curve_x0[1] = gspl_pkg::RST_SMOKE_X0;
		curve_y0[1] = gspl_pkg::RST_SMOKE_Y0;
		curve_slope[1] = gspl_pkg::RST_SMOKE_SLOPE;
		root_k[0] = floor_sqrt(64'd1 << 61);
		for (int i = 1; i < 16; i++)
			root_k[i] = floor_sqrt(root_k[i - 1] << 30);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_curves();
		test_special_settings();
		test_random_samples(35, 65, 500);
		test_random_samples(65, 35, 500);
		test_random_samples(0, 0, 530);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
